// ===== rtl/json_byte_tokenizer_assert.svh =====
// Assertion macros for the JSON byte tokenizer.
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jbt assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jbt assertion failed");
`else
`define JBT_ASSERT_IMP(lbl, ante, cons)
`define JBT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/jbt_pkg.sv =====
// Types, codes and lookup functions for the JSON byte tokenizer.
package jbt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KIND_W            = 4;
    localparam int FIELD_W           = 16;
    localparam int OUT_DATA_W        = 40;  // 36 payload bits rounded up to bytes

    // token kind codes
    localparam logic [KIND_W-1:0] KIND_LBRACKET = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RBRACKET = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_COLON    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_STRING   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_NULL     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_FALSE    = 4'd10;

    // character codes
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_UPPER_E  = 8'h45;
    localparam logic [7:0] CH_LOWER_E  = 8'h65;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;

    // keyword ids
    localparam logic [1:0] KW_NULL  = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_FALSE = 2'd2;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_STRING  = 4'b0010,
        MODE_NUMBER  = 4'b0100,
        MODE_KEYWORD = 4'b1000
    } lex_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } token_t;

    function automatic logic [2:0] kw_len(input logic [1:0] id);
        return (id == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    // expected byte of keyword id at character index idx
    function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (id)
            KW_NULL:
            begin
                case (idx)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = 8'h00;
                endcase
            end
            KW_TRUE:
            begin
                case (idx)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            KW_FALSE:
            begin
                case (idx)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic in_number_set(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_PLUS ||
               b == CH_DOT || b == CH_UPPER_E || b == CH_LOWER_E;
    endfunction

    function automatic token_t make_token(input logic [KIND_W-1:0] kind,
                                          input logic [FIELD_W-1:0] start,
                                          input logic [FIELD_W-1:0] length);
        token_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

// ===== rtl/json_byte_tokenizer.sv =====
// Streaming JSON lexer: one text byte per request in, one token per request out.
//
// Input channel (s_*): tdata[7:0] is the text byte, tlast marks the final byte
// of a text. Output channel (m_*): tdata carries kind, start offset and length
// of one token, tlast is set on the last token that a given byte produced.
// Tokens: [ ] { } : , (length 0), string (start after the quote, content
// length with escapes counted), number, and the keywords null/true/false
// (length 0). Whitespace and unknown bytes produce nothing.
//
// Path: a byte accepted into the input register is decoded there, and its
// tokens are written into the token queue; the first is then offered on m_*.
// Throughput: one byte per cycle. The only per-byte work is the lexer state
// update between the input register and a two-entry token queue. A byte that
// both closes a number and is punctuation yields two tokens, which leave on
// m_* one after the other; the input stage waits only when the queue lacks
// room for what the pending byte produces.
// Stall: when m_tready is low the queue fills, the input register holds its
// byte and s_tready drops; nothing is lost or repeated.
// Reset: queue and input register empty, lexer idle, offset 0. The offset
// also returns to 0 after each byte marked by s_tlast. Offsets and lengths
// saturate at 2^POSITION_BITS - 1 and are reported in 16 bits.
`include "json_byte_tokenizer_assert.svh"

module json_byte_tokenizer
    import jbt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] in_byte
    input  logic                  s_tlast,   // end_of_input
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] kind, [19:4] start, [35:20] length
    output logic                  m_tlast    // last token of this byte
);

    // ---------------- input register ----------------
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_fire;

    // ---------------- lexer state ----------------
    lex_mode_t              mode_reg, mode_next;
    logic                   esc_reg, esc_next;
    logic [1:0]             kw_id_reg, kw_id_next;
    logic [2:0]             kw_prog_reg, kw_prog_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [POSITION_BITS-1:0] plen_reg, plen_next;

    // ---------------- token queue ----------------
    token_t     q_reg [2];
    token_t     q_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] cnt_after_pop;

    // tokens produced by the byte in the input register
    token_t     tok [2];
    logic [1:0] ntok;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POSITION_BITS'(1);
    endfunction

    // ---------------- per-byte lexer step ----------------
    always_comb
    begin
        logic       b_end;
        logic [7:0] b;
        logic       do_fresh;
        b        = s1_byte_reg;
        b_end    = s1_last_reg;
        do_fresh = 1'b0;

        mode_next    = mode_reg;
        esc_next     = esc_reg;
        kw_id_next   = kw_id_reg;
        kw_prog_next = kw_prog_reg;
        pstart_next  = pstart_reg;
        plen_next    = plen_reg;
        pos_next     = b_end ? '0 : sat_inc(pos_reg);

        ntok   = 2'd0;
        tok[0] = make_token(KIND_LBRACKET, '0, '0);
        tok[1] = make_token(KIND_LBRACKET, '0, '0);

        unique case (mode_reg)
            MODE_STRING:
            begin
                if (!esc_reg && b == CH_QUOTE)
                begin
                    tok[0]    = make_token(KIND_STRING, FIELD_W'(pstart_reg),
                                           FIELD_W'(plen_reg));
                    ntok      = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    esc_next  = !esc_reg && b == CH_BSLASH;
                    plen_next = sat_inc(plen_reg);
                    if (b_end)
                    begin
                        // unterminated string flushes at end of text
                        tok[0] = make_token(KIND_STRING, FIELD_W'(pstart_reg),
                                            FIELD_W'(sat_inc(plen_reg)));
                        ntok   = 2'd1;
                    end
                end
            end
            MODE_NUMBER:
            begin
                if (in_number_set(b))
                begin
                    plen_next = sat_inc(plen_reg);
                    if (b_end)
                    begin
                        tok[0] = make_token(KIND_NUMBER, FIELD_W'(pstart_reg),
                                            FIELD_W'(sat_inc(plen_reg)));
                        ntok   = 2'd1;
                    end
                end
                else
                begin
                    // close the number, then treat this byte as new
                    tok[0]   = make_token(KIND_NUMBER, FIELD_W'(pstart_reg),
                                          FIELD_W'(plen_reg));
                    ntok     = 2'd1;
                    do_fresh = 1'b1;
                end
            end
            MODE_KEYWORD:
            begin
                if (b == kw_char(kw_id_reg, kw_prog_reg))
                begin
                    kw_prog_next = kw_prog_reg + 3'd1;
                    if (kw_prog_reg + 3'd1 == kw_len(kw_id_reg))
                    begin
                        tok[0]    = make_token(KIND_NULL + KIND_W'(kw_id_reg),
                                               FIELD_W'(pstart_reg), '0);
                        ntok      = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                else
                begin
                    do_fresh = 1'b1;  // drop the partial keyword
                end
            end
            MODE_IDLE:
            begin
                do_fresh = 1'b1;
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_fresh)
        begin
            mode_next = MODE_IDLE;
            case (b)
                CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE, CH_COLON, CH_COMMA:
                begin
                    tok[ntok[0]] = make_token(
                        (b == CH_LBRACKET) ? KIND_LBRACKET :
                        (b == CH_RBRACKET) ? KIND_RBRACKET :
                        (b == CH_LBRACE)   ? KIND_LBRACE   :
                        (b == CH_RBRACE)   ? KIND_RBRACE   :
                        (b == CH_COLON)    ? KIND_COLON    : KIND_COMMA,
                        FIELD_W'(pos_reg), '0);
                    ntok = ntok + 2'd1;
                end
                CH_QUOTE:
                begin
                    if (!b_end)  // a quote as final byte opens nothing
                    begin
                        mode_next   = MODE_STRING;
                        pstart_next = sat_inc(pos_reg);
                        plen_next   = '0;
                        esc_next    = 1'b0;
                    end
                end
                CH_N, CH_T, CH_F:
                begin
                    if (!b_end)
                    begin
                        mode_next    = MODE_KEYWORD;
                        kw_id_next   = (b == CH_N) ? KW_NULL :
                                       (b == CH_T) ? KW_TRUE : KW_FALSE;
                        kw_prog_next = 3'd1;
                        pstart_next  = pos_reg;
                    end
                end
                default:
                begin
                    if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS)
                    begin
                        pstart_next = pos_reg;
                        plen_next   = POSITION_BITS'(1);
                        if (b_end)
                        begin
                            tok[ntok[0]] = make_token(KIND_NUMBER, FIELD_W'(pos_reg),
                                                      FIELD_W'(1));
                            ntok = ntok + 2'd1;
                        end
                        else
                        begin
                            mode_next = MODE_NUMBER;
                        end
                    end
                end
            endcase
        end

        if (ntok != 2'd0)
        begin
            tok[ntok[0] ^ 1'b1].last = 1'b1;  // index ntok-1 for ntok of 1 or 2
        end

        if (b_end)
        begin
            mode_next    = MODE_IDLE;
            esc_next     = 1'b0;
            kw_id_next   = KW_NULL;
            kw_prog_next = 3'd0;
            pstart_next  = '0;
            plen_next    = '0;
        end
    end

    // ---------------- handshakes ----------------
    assign pop           = m_tvalid && m_tready;
    assign cnt_after_pop = cnt_reg - {1'b0, pop};
    // the byte moves on once the queue has room for every token it yields
    assign s1_fire       = s1_valid_reg && ({1'b0, cnt_after_pop} + {1'b0, ntok} <= 3'd2);
    assign s_tready      = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            esc_reg     <= 1'b0;
            kw_id_reg   <= KW_NULL;
            kw_prog_reg <= 3'd0;
            pos_reg     <= '0;
            pstart_reg  <= '0;
            plen_reg    <= '0;
        end
        else if (s1_fire)
        begin
            mode_reg    <= mode_next;
            esc_reg     <= esc_next;
            kw_id_reg   <= kw_id_next;
            kw_prog_reg <= kw_prog_next;
            pos_reg     <= pos_next;
            pstart_reg  <= pstart_next;
            plen_reg    <= plen_next;
        end
    end

    // ---------------- token queue ----------------
    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        cnt_next = cnt_after_pop;
        if (s1_fire)
        begin
            if (ntok != 2'd0)
            begin
                q_next[cnt_after_pop[0]] = tok[0];
            end
            if (ntok == 2'd2)
            begin
                q_next[1] = tok[1];  // two tokens only fit into an empty queue
            end
            cnt_next = cnt_after_pop + ntok;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {(OUT_DATA_W - KIND_W - 2 * FIELD_W)'(0),
                       q_reg[0].length, q_reg[0].start, q_reg[0].kind};
    assign m_tlast  = q_reg[0].last;

    // ---------------- checks ----------------
    `JBT_ASSERT_IMP(a_queue_bound, 1'b1, cnt_reg <= 2'd2)
    `JBT_ASSERT_IMP(a_kind_legal, m_tvalid, q_reg[0].kind <= KIND_FALSE)
    `JBT_ASSERT_NXT(a_end_resets, s1_fire && s1_last_reg, pos_reg == '0 && mode_reg == MODE_IDLE)
    `JBT_ASSERT_IMP(a_string_start, mode_reg == MODE_STRING, pstart_reg != '0)
    `JBT_ASSERT_NXT(a_hold_byte, s1_valid_reg && !s1_fire, s1_valid_reg && $stable(s1_byte_reg))

endmodule
